/* design/pap_pkg.sv */
`timescale 1ns / 1ps

package pap_pkg;

  localparam int COORD_W       = 16;
  localparam int FRACTION_BITS = 8;
  localparam int MAX_VERTICES  = 4096;

  localparam int CNT_W   = 13;
  localparam int CROSS_W = 45;
  localparam int AREA_W  = 44;
  localparam int PERIM_W = 37;

  // Multiplier operands are wide enough to hold a coordinate difference.
  localparam int OP_W   = COORD_W + 1;
  localparam int PROD_W = 2 * OP_W;

  // Sum of two squares, unsigned.
  localparam int SQ_W   = 2 * COORD_W + 1;
  localparam int ROOT_W = (SQ_W + 1) / 2 + FRACTION_BITS;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;
  localparam int ITER_W = $clog2(ROOT_W);

endpackage

/* design/pap_isqrt.sv */
`timescale 1ns / 1ps

module pap_isqrt
  import pap_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SQ_W-1:0]   radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic              busy_r;
  logic              done_r;
  logic [ITER_W-1:0] it_r;
  logic [RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;

  logic [REM_W-1:0]  rem_shift;
  logic [REM_W-1:0]  trial;
  logic              take;

  assign rem_shift = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
  assign trial     = {root_r, 2'b01};
  assign take      = (rem_shift >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        it_r   <= ITER_W'(ROOT_W - 1);
        rad_r  <= RAD_W'(radicand) << (2 * FRACTION_BITS);
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        rad_r  <= rad_r << 2;
        rem_r  <= take ? (rem_shift - trial) : rem_shift;
        root_r <= {root_r[ROOT_W-2:0], take};
        it_r   <= it_r - 1'b1;
        if (it_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

/* design/polygon_area_perimeter.sv */
`timescale 1ns / 1ps

// Channel   Ports                                                   Direction
// in        in_valid/in_ready, in_x_coord, in_y_coord,              vertex beat in
//           in_last_vertex
// out       out_valid/out_ready, out_twice_area, out_clockwise,     polygon result out
//           out_perimeter, out_vertex_total, out_overflow
//
// The first vertex of a polygon is stored; every other vertex up to MAX_VERTICES runs
// one edge: a difference state, five multiplier steps and the 25-step square root
// that starts on the fourth step. Vertices beyond MAX_VERTICES are dropped and set
// the overflow flag. A last vertex adds the closing edge and an output state.
// Synchronous active-low reset clears the sums, the count and both channels.
// in_ready is low while an edge runs; a result held by out_ready stalls only
// the next polygon's closing.

module polygon_area_perimeter
  import pap_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] in_x_coord,
  input  logic signed [COORD_W-1:0] in_y_coord,
  input  logic                      in_last_vertex,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [AREA_W-1:0]         out_twice_area,
  output logic                      out_clockwise,
  output logic [PERIM_W-1:0]        out_perimeter,
  output logic [CNT_W-1:0]          out_vertex_total,
  output logic                      out_overflow
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_MUL,
    S_ROOT,
    S_OUT
  } state_t;

  localparam logic [2:0] MUL_LAST = 3'd4;

  state_t                     state_r;
  logic [2:0]                 step_r;
  logic signed [COORD_W-1:0]  first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic signed [COORD_W-1:0]  ax_r, ay_r, bx_r, by_r;
  logic signed [OP_W-1:0]     dx_r, dy_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic [SQ_W-1:0]            sq_r;
  logic [CROSS_W-1:0]         cross_r;
  logic [PERIM_W-1:0]         perim_r;
  logic [CNT_W-1:0]           count_r;
  logic                       ovf_r;
  logic                       close_pend_r;
  logic                       closing_r;

  logic                       out_valid_r;
  logic [AREA_W-1:0]          out_area_r;
  logic                       out_cw_r;
  logic [PERIM_W-1:0]         out_perim_r;
  logic [CNT_W-1:0]           out_count_r;
  logic                       out_ovf_r;

  logic signed [OP_W-1:0]     mul_a, mul_b;
  logic signed [PROD_W-1:0]   prod;
  logic [CROSS_W-1:0]         prod_ext;
  logic [PERIM_W:0]           perim_sum;
  logic [CROSS_W-1:0]         cross_mag;
  logic                       root_start;
  logic                       root_done;
  logic [ROOT_W-1:0]          root_val;
  logic                       out_load;

  pap_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .radicand (sq_r),
    .done     (root_done),
    .root     (root_val)
  );

  always_comb begin
    case (step_r)
      3'd0: begin
        mul_a = dx_r;
        mul_b = dx_r;
      end
      3'd1: begin
        mul_a = dy_r;
        mul_b = dy_r;
      end
      3'd2: begin
        mul_a = OP_W'(ax_r);
        mul_b = OP_W'(by_r);
      end
      default: begin
        mul_a = OP_W'(bx_r);
        mul_b = OP_W'(ay_r);
      end
    endcase
  end

  assign prod       = mul_a * mul_b;
  assign prod_ext   = {{(CROSS_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign perim_sum  = {1'b0, perim_r} + (PERIM_W + 1)'(root_val);
  assign cross_mag  = cross_r[CROSS_W-1] ? ({CROSS_W{1'b0}} - cross_r) : cross_r;
  assign root_start = (state_r == S_MUL) && (step_r == 3'd3);
  assign out_load   = (state_r == S_OUT) && (!out_valid_r || out_ready);
  assign in_ready   = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      step_r       <= '0;
      cross_r      <= '0;
      perim_r      <= '0;
      count_r      <= '0;
      ovf_r        <= 1'b0;
      close_pend_r <= 1'b0;
      closing_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (count_r == '0) begin
              first_x_r <= in_x_coord;
              first_y_r <= in_y_coord;
              prev_x_r  <= in_x_coord;
              prev_y_r  <= in_y_coord;
              count_r   <= CNT_W'(1);
              if (in_last_vertex) begin
                ax_r         <= in_x_coord;
                ay_r         <= in_y_coord;
                bx_r         <= in_x_coord;
                by_r         <= in_y_coord;
                close_pend_r <= 1'b0;
                closing_r    <= 1'b1;
                state_r      <= S_DIFF;
              end
            end else if (count_r < CNT_W'(MAX_VERTICES)) begin
              ax_r         <= prev_x_r;
              ay_r         <= prev_y_r;
              bx_r         <= in_x_coord;
              by_r         <= in_y_coord;
              prev_x_r     <= in_x_coord;
              prev_y_r     <= in_y_coord;
              count_r      <= count_r + 1'b1;
              close_pend_r <= in_last_vertex;
              closing_r    <= 1'b0;
              state_r      <= S_DIFF;
            end else begin
              ovf_r <= 1'b1;
              if (in_last_vertex) begin
                ax_r         <= prev_x_r;
                ay_r         <= prev_y_r;
                bx_r         <= first_x_r;
                by_r         <= first_y_r;
                close_pend_r <= 1'b0;
                closing_r    <= 1'b1;
                state_r      <= S_DIFF;
              end
            end
          end
        end
        S_DIFF: begin
          dx_r    <= OP_W'(bx_r) - OP_W'(ax_r);
          dy_r    <= OP_W'(by_r) - OP_W'(ay_r);
          step_r  <= '0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r <= prod;
          step_r <= step_r + 1'b1;
          case (step_r)
            3'd1:    sq_r    <= prod_r[SQ_W-1:0];
            3'd2:    sq_r    <= sq_r + prod_r[SQ_W-1:0];
            3'd3:    cross_r <= cross_r + prod_ext;
            3'd4:    cross_r <= cross_r - prod_ext;
            default: ;
          endcase
          if (step_r == MUL_LAST) begin
            state_r <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (root_done) begin
            perim_r <= perim_sum[PERIM_W] ? {PERIM_W{1'b1}} : perim_sum[PERIM_W-1:0];
            if (close_pend_r) begin
              ax_r         <= prev_x_r;
              ay_r         <= prev_y_r;
              bx_r         <= first_x_r;
              by_r         <= first_y_r;
              close_pend_r <= 1'b0;
              closing_r    <= 1'b1;
              state_r      <= S_DIFF;
            end else if (closing_r) begin
              state_r <= S_OUT;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            out_area_r  <= cross_mag[AREA_W-1:0];
            out_cw_r    <= cross_r[CROSS_W-1];
            out_perim_r <= perim_r;
            out_count_r <= count_r;
            out_ovf_r   <= ovf_r;
            cross_r     <= '0;
            perim_r     <= '0;
            count_r     <= '0;
            ovf_r       <= 1'b0;
            closing_r   <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_twice_area   = out_area_r;
  assign out_clockwise    = out_cw_r;
  assign out_perimeter    = out_perim_r;
  assign out_vertex_total = out_count_r;
  assign out_overflow     = out_ovf_r;

`ifndef SYNTHESIS
  a_root_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    root_done |-> (state_r == S_ROOT))
    else $error("root finished outside its wait state");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_VERTICES))
    else $error("vertex count beyond maximum");

  a_clear_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (count_r == '0) && (cross_r == '0) && (perim_r == '0) && !ovf_r)
    else $error("sums not cleared after result load");

  a_result_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_count_r != '0))
    else $error("result beat with zero vertices");
`endif

endmodule
